[sv/bsmg_pkg.sv]
package bsmg_pkg;

    localparam int DEF_MAX_SPHERES        = 1024;
    localparam int DEF_MAX_CELLS_PER_AXIS = 8;
    localparam int DEF_MAX_PER_CELL       = 32;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int CELLS_W   = 4;
    localparam int LEN_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W      = 66;
    localparam int ROOT_W    = 34;
    localparam int GAP_W     = 36;

    localparam logic [COORD_W-1:0] INFINITY  = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Z   = 3'd5;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

[sv/binned_sphere_min_gap_top.sv]
// Uniform-grid sphere gap finder. Spheres arrive one item at a time and are binned into up to
// MAX_CELLS_PER_AXIS^3 cells by the eight corners of their bounding cube; the item flagged
// last_sphere then triggers a pass over every cell that tests each pair sharing it and returns
// one result: least center distance minus radius sum, a no-pair flag and an overflow flag.
// After reset the cell fill table is swept, one cell a cycle, before the first item is taken.
// After each item the input stays busy while every corner runs clog2(M) + 1 restoring divider
// steps on all three axes at once (M = MAX_CELLS_PER_AXIS), then the fill memory read and, for
// a corner whose cell already holds entries, a member memory check. The final item then reads
// the fill of each cell and, for each tested pair, both members and their stored spheres (the
// first member is read once for all its partners), and sums the squared axis differences on
// the shared 32x32 squarer before the 34-step bit-serial square root.
module binned_sphere_min_gap_top #(
    parameter int MAX_SPHERES        = bsmg_pkg::DEF_MAX_SPHERES,
    parameter int MAX_CELLS_PER_AXIS = bsmg_pkg::DEF_MAX_CELLS_PER_AXIS,
    parameter int MAX_PER_CELL       = bsmg_pkg::DEF_MAX_PER_CELL
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsmg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bsmg_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [bsmg_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [bsmg_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [bsmg_pkg::COORD_W-1:0] i_center_z,
    input  logic [bsmg_pkg::RAD_W-1:0]          i_sphere_radius,
    input  logic                                i_last_sphere,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bsmg_pkg::COORD_W-1:0] o_min_gap,
    output logic                                o_no_pair,
    output logic                                o_cell_overflow
);
    import bsmg_pkg::*;

    localparam int M         = MAX_CELLS_PER_AXIS;
    localparam int NUM_CELLS = M * M * M;
    localparam int KQ        = $clog2(M);
    localparam int QW        = KQ + 1;
    localparam int IW        = (KQ > 0) ? KQ : 1;
    localparam int CW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int MW        = $clog2(NUM_CELLS * MAX_PER_CELL);
    localparam int FW        = $clog2(MAX_PER_CELL + 1);
    localparam int SIDW      = $clog2(MAX_SPHERES);
    localparam int CNTW      = $clog2(MAX_SPHERES + 1);
    localparam int LW        = COORD_W + KQ + 2;
    localparam int PW        = COORD_W + 2;
    localparam int ST_W      = 3 * COORD_W + RAD_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOAD, S_CORNER, S_DIV, S_CELL, S_FRD, S_FCHK, S_MCHK, S_NEXT,
        S_P_FRD, S_P_FCHK, S_P_IRD, S_P_ISRD, S_P_ILAT, S_P_JRD, S_P_JSRD, S_P_JLAT,
        S_P_SQ, S_P_SQRT, S_P_CMP, S_P_NEXT, S_OUT
    } t_state;

    t_state                    r_state;
    logic [CELLS_W-1:0]        r_cells [3];
    logic [LEN_W-1:0]          r_len   [3];
    logic [COORD_W-1:0]        r_in_c  [3];
    logic [RAD_W-1:0]          r_in_r;
    logic                      r_last;
    logic [CNTW-1:0]           r_count;
    logic [SIDW-1:0]           r_sid;
    logic                      r_ovf;
    logic [2:0]                r_corner;
    logic [LW-1:0]             r_rem   [3];
    logic [QW-1:0]             r_q     [3];
    logic                      r_neg   [3];
    logic                      r_sat   [3];
    logic [QW-1:0]             r_k;
    logic [CW-1:0]             r_cell;
    logic [CW-1:0]             r_b;
    logic [FW-1:0]             r_pf;
    logic [FW-1:0]             r_pi;
    logic [FW-1:0]             r_pj;
    logic [ST_W-1:0]           r_si;
    logic [ST_W-1:0]           r_sj;
    logic [1:0]                r_sk;
    logic [SQ_W-1:0]           r_prod;
    logic [SQ_W-1:0]           r_sum;
    logic                      r_sqrt_start;
    logic signed [GAP_W-1:0]   r_gap;
    logic signed [GAP_W-1:0]   r_best;
    logic                      r_found;

    logic [ST_W-1:0]           m_store [MAX_SPHERES];
    logic [FW-1:0]             m_fill  [NUM_CELLS];
    logic [SIDW-1:0]           m_mem   [NUM_CELLS * MAX_PER_CELL];
    logic [ST_W-1:0]           r_store_rd;
    logic [FW-1:0]             r_fill_rd;
    logic [SIDW-1:0]           r_mem_rd;

    logic                      st_we;
    logic                      fill_we;
    logic [CW-1:0]             fill_wa;
    logic [FW-1:0]             fill_wd;
    logic [CW-1:0]             fill_ra;
    logic                      ins_we;
    logic [MW-1:0]             mem_wa;
    logic [MW-1:0]             mem_ra;

    logic [LEN_W-1:0]          len_eff [3];
    logic [7:0]                nm1     [3];
    logic [PW-1:0]             pc      [3];
    logic [IW-1:0]             idx     [3];
    logic [COORD_W-1:0]        ai;
    logic [COORD_W-1:0]        aj;
    logic [COORD_W:0]          dd;
    logic [COORD_W:0]          du;
    logic [2*COORD_W-1:0]      sq_lo;
    logic [SQ_W-1:0]           sq;
    logic [GAP_W-1:0]          rsum;
    logic                      gap_fits;
    logic                      div_last;

    t_sqrt_req                 sqrt_req;
    t_sqrt_rsp                 sqrt_rsp;

    bsmg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign sqrt_req.start    = r_sqrt_start;
    assign sqrt_req.radicand = r_sum;

    always_comb begin
        logic [7:0] c8;
        logic [7:0] v;
        for (int a = 0; a < 3; a++) begin
            len_eff[a] = (r_len[a] == '0) ? LEN_W'(1) : r_len[a];
            c8 = 8'(r_cells[a]);
            if (c8 == 8'd0) begin
                c8 = 8'd1;
            end else if (c8 > 8'(M)) begin
                c8 = 8'(M);
            end
            nm1[a] = c8 - 8'd1;
            if (r_corner[2-a]) begin
                pc[a] = PW'($signed(r_in_c[a])) + PW'(r_in_r);
            end else begin
                pc[a] = PW'($signed(r_in_c[a])) - PW'(r_in_r);
            end
            if (r_neg[a]) begin
                v = 8'd0;
            end else if (r_sat[a] || (8'(r_q[a]) > nm1[a])) begin
                v = nm1[a];
            end else begin
                v = 8'(r_q[a]);
            end
            idx[a] = IW'(v);
        end
    end

    always_comb begin
        case (r_sk)
            2'd0:    begin ai = r_si[ST_W-1 -: COORD_W];           aj = r_sj[ST_W-1 -: COORD_W]; end
            2'd1:    begin ai = r_si[ST_W-1-COORD_W -: COORD_W];   aj = r_sj[ST_W-1-COORD_W -: COORD_W]; end
            default: begin ai = r_si[RAD_W +: COORD_W];            aj = r_sj[RAD_W +: COORD_W]; end
        endcase
        dd    = {ai[COORD_W-1], ai} - {aj[COORD_W-1], aj};
        du    = dd[COORD_W] ? (~dd + (COORD_W + 1)'(1)) : dd;
        sq_lo = du[COORD_W-1:0] * du[COORD_W-1:0];
        sq    = du[COORD_W] ? (SQ_W'(1) << (2 * COORD_W)) : SQ_W'(sq_lo);
        rsum  = GAP_W'(r_si[RAD_W-1:0]) + GAP_W'(r_sj[RAD_W-1:0]);
    end

    assign gap_fits = (r_best[GAP_W-1:COORD_W-1] == '0) || (r_best[GAP_W-1:COORD_W-1] == '1);
    assign div_last = (r_k == '0);

    assign ins_we  = ((r_state == S_FCHK) && (r_fill_rd == '0)) ||
                     ((r_state == S_MCHK) && (r_mem_rd != r_sid) &&
                      (r_fill_rd < FW'(MAX_PER_CELL)));
    assign mem_wa  = MW'(r_cell) * MW'(MAX_PER_CELL) + MW'(r_fill_rd);
    assign st_we   = (r_state == S_LOAD) && (r_count < CNTW'(MAX_SPHERES));
    assign fill_ra = (r_state == S_P_FRD) ? r_b : r_cell;

    always_comb begin
        fill_we = 1'b0;
        fill_wa = r_cell;
        fill_wd = r_fill_rd + FW'(1);
        if (r_state == S_CLR || r_state == S_P_FRD) begin
            fill_we = 1'b1;
            fill_wa = r_b;
            fill_wd = '0;
        end else if (ins_we) begin
            fill_we = 1'b1;
        end
    end

    always_comb begin
        unique case (r_state)
            S_P_IRD: mem_ra = MW'(r_b) * MW'(MAX_PER_CELL) + MW'(r_pi);
            S_P_JRD: mem_ra = MW'(r_b) * MW'(MAX_PER_CELL) + MW'(r_pj);
            default: mem_ra = MW'(r_cell) * MW'(MAX_PER_CELL) + MW'(r_fill_rd) - MW'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_store[SIDW'(r_count)] <= {r_in_c[0], r_in_c[1], r_in_c[2], r_in_r};
        end
        r_store_rd <= m_store[r_mem_rd];
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            m_fill[fill_wa] <= fill_wd;
        end
        r_fill_rd <= m_fill[fill_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ins_we) begin
            m_mem[mem_wa] <= r_sid;
        end
        r_mem_rd <= m_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLR;
            r_b             <= '0;
            r_count         <= '0;
            r_ovf           <= 1'b0;
            r_found         <= 1'b0;
            r_sqrt_start    <= 1'b0;
            o_out_valid     <= 1'b0;
            o_in_ready      <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_cells[a] <= CELLS_W'(1);
                r_len[a]   <= LEN_W'(65536);
            end
        end else begin
            r_sqrt_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CELLS_X: r_cells[0] <= i_cfg_data[CELLS_W-1:0];
                    REG_CELLS_Y: r_cells[1] <= i_cfg_data[CELLS_W-1:0];
                    REG_CELLS_Z: r_cells[2] <= i_cfg_data[CELLS_W-1:0];
                    REG_LEN_X:   r_len[0]   <= i_cfg_data[LEN_W-1:0];
                    REG_LEN_Y:   r_len[1]   <= i_cfg_data[LEN_W-1:0];
                    REG_LEN_Z:   r_len[2]   <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_b == CW'(NUM_CELLS - 1)) begin
                        r_state    <= S_IDLE;
                        o_in_ready <= 1'b1;
                    end else begin
                        r_b <= r_b + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_c[0]  <= i_center_x;
                        r_in_c[1]  <= i_center_y;
                        r_in_c[2]  <= i_center_z;
                        r_in_r     <= i_sphere_radius;
                        r_last     <= i_last_sphere;
                        o_in_ready <= 1'b0;
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_corner <= '0;
                    r_b      <= '0;
                    r_found  <= 1'b0;
                    if (st_we) begin
                        r_sid   <= SIDW'(r_count);
                        r_count <= r_count + CNTW'(1);
                        r_state <= S_CORNER;
                    end else begin
                        r_ovf <= 1'b1;
                        if (r_last) begin
                            r_state <= S_P_FRD;
                        end else begin
                            r_state    <= S_IDLE;
                            o_in_ready <= 1'b1;
                        end
                    end
                end
                S_CORNER: begin
                    for (int a = 0; a < 3; a++) begin
                        r_neg[a] <= pc[a][PW-1];
                        r_rem[a] <= LW'(pc[a][PW-2:0]);
                        r_sat[a] <= LW'(pc[a][PW-2:0]) >= (LW'(len_eff[a]) << (KQ + 1));
                        r_q[a]   <= '0;
                    end
                    r_k     <= QW'(KQ);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    for (int a = 0; a < 3; a++) begin
                        if (r_rem[a] >= (LW'(len_eff[a]) << r_k)) begin
                            r_rem[a] <= r_rem[a] - (LW'(len_eff[a]) << r_k);
                            r_q[a]   <= r_q[a] | (QW'(1) << r_k);
                        end
                    end
                    r_k <= r_k - QW'(1);
                    if (div_last) begin
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_cell  <= CW'((32'(idx[0]) * 32'(M) + 32'(idx[1])) * 32'(M) + 32'(idx[2]));
                    r_state <= S_FRD;
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    r_state <= (r_fill_rd == '0) ? S_NEXT : S_MCHK;
                end
                S_MCHK: begin
                    if (r_mem_rd != r_sid && r_fill_rd >= FW'(MAX_PER_CELL)) begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_corner == 3'd7) begin
                        if (r_last) begin
                            r_state <= S_P_FRD;
                        end else begin
                            r_state    <= S_IDLE;
                            o_in_ready <= 1'b1;
                        end
                    end else begin
                        r_corner <= r_corner + 3'd1;
                        r_state  <= S_CORNER;
                    end
                end
                S_P_FRD: begin
                    r_state <= S_P_FCHK;
                end
                S_P_FCHK: begin
                    r_pf <= r_fill_rd;
                    r_pi <= '0;
                    r_state <= (r_fill_rd < FW'(2)) ? S_P_NEXT : S_P_IRD;
                end
                S_P_IRD: begin
                    r_state <= S_P_ISRD;
                end
                S_P_ISRD: begin
                    r_pj    <= r_pi + FW'(1);
                    r_state <= S_P_ILAT;
                end
                S_P_ILAT: begin
                    r_si    <= r_store_rd;
                    r_state <= S_P_JRD;
                end
                S_P_JRD: begin
                    r_state <= S_P_JSRD;
                end
                S_P_JSRD: begin
                    r_state <= S_P_JLAT;
                end
                S_P_JLAT: begin
                    r_sj    <= r_store_rd;
                    r_sk    <= '0;
                    r_sum   <= '0;
                    r_state <= S_P_SQ;
                end
                S_P_SQ: begin
                    r_prod <= sq;
                    if (r_sk != 2'd0) begin
                        r_sum <= r_sum + r_prod;
                    end
                    r_sk <= r_sk + 2'd1;
                    if (r_sk == 2'd3) begin
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_P_SQRT;
                    end
                end
                S_P_SQRT: begin
                    if (sqrt_rsp.done) begin
                        r_gap   <= $signed(GAP_W'(sqrt_rsp.root)) - $signed(rsum);
                        r_state <= S_P_CMP;
                    end
                end
                S_P_CMP: begin
                    if (!r_found || r_gap < r_best) begin
                        r_best <= r_gap;
                    end
                    r_found <= 1'b1;
                    if ((FW + 1)'(r_pj) + (FW + 1)'(1) < (FW + 1)'(r_pf)) begin
                        r_pj    <= r_pj + FW'(1);
                        r_state <= S_P_JRD;
                    end else if ((FW + 1)'(r_pi) + (FW + 1)'(2) < (FW + 1)'(r_pf)) begin
                        r_pi    <= r_pi + FW'(1);
                        r_state <= S_P_IRD;
                    end else begin
                        r_state <= S_P_NEXT;
                    end
                end
                S_P_NEXT: begin
                    if (r_b == CW'(NUM_CELLS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_b     <= r_b + CW'(1);
                        r_state <= S_P_FRD;
                    end
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid     <= 1'b1;
                        o_no_pair       <= !r_found;
                        o_cell_overflow <= r_ovf;
                        if (!r_found) begin
                            o_min_gap <= INFINITY;
                        end else if (gap_fits) begin
                            o_min_gap <= r_best[COORD_W-1:0];
                        end else begin
                            o_min_gap <= r_best[GAP_W-1] ? NEG_LIMIT : INFINITY;
                        end
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= S_IDLE;
                        o_in_ready <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/bsmg_isqrt.sv]
module bsmg_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsmg_pkg::t_sqrt_req i_req,
    output bsmg_pkg::t_sqrt_rsp o_rsp
);
    import bsmg_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    assign rem_sh = {r_rem, r_rad[PAD_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({r_root, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rad  <= PAD_W'(i_req.radicand);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[PAD_W-3:0], 2'b00};
                r_rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

[sv/bsmg_checker.sv]
module bsmg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [bsmg_pkg::COORD_W-1:0] o_min_gap,
    input logic                                o_no_pair,
    input logic                                o_cell_overflow
);
    import bsmg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_min_gap) && $stable(o_no_pair)
            && $stable(o_cell_overflow))
        else $error("stalled result changed");

    a_no_pair_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_pair |-> o_min_gap == INFINITY)
        else $error("no pair without saturated gap");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an item");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("handshake not cleared by reset");

endmodule

bind binned_sphere_min_gap_top bsmg_checker u_bsmg_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bsmg_pkg::*;

    localparam int N_SPH  = DEF_MAX_SPHERES;
    localparam int N_AX   = DEF_MAX_CELLS_PER_AXIS;
    localparam int N_PER  = DEF_MAX_PER_CELL;
    localparam int N_CELL = N_AX * N_AX * N_AX;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RAD_W-1:0]          rad;
        logic                      last;
    } t_sphere;

    typedef struct {
        logic signed [COORD_W-1:0] gap;
        logic                      no_pair;
        logic                      ovf;
    } t_gap_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic signed [COORD_W-1:0]   i_center_x = '0;
    logic signed [COORD_W-1:0]   i_center_y = '0;
    logic signed [COORD_W-1:0]   i_center_z = '0;
    logic [RAD_W-1:0]            i_sphere_radius = '0;
    logic                        i_last_sphere = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [COORD_W-1:0]   o_min_gap;
    logic                        o_no_pair;
    logic                        o_cell_overflow;

    binned_sphere_min_gap_top u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // grid model
    logic [3:0]         grid_cells [3];
    logic [LEN_W-1:0]   grid_len [3];
    logic [31:0]        sph_x [N_SPH];
    logic [31:0]        sph_y [N_SPH];
    logic [31:0]        sph_z [N_SPH];
    logic [31:0]        sph_r [N_SPH];
    int                 sph_count;
    int                 bin_fill [N_CELL];
    int                 bin_member [N_CELL*N_PER];
    bit                 dropped;

    t_sphere            pending_q [$];
    t_gap_result        gap_q [$];
    int                 errors;
    int                 n_items;
    int                 n_results;
    int                 n_sets;
    int                 n_overflow;
    int                 n_nopair;
    int                 n_settings;
    bit                 burst;

    function automatic int axis_bin(longint c, int k);
        longint n;
        longint len;
        longint q;
        n = grid_cells[k];
        if (n < 1) n = 1;
        if (n > N_AX) n = N_AX;
        len = grid_len[k];
        if (len == 0) len = 1;
        if (c < 0) return 0;
        q = c / len;
        if (q > n - 1) q = n - 1;
        return int'(q);
    endfunction

    function automatic longint surface_gap(int i, int j);
        logic [67:0] acc;
        logic [67:0] u;
        logic [67:0] tt;
        logic [33:0] root;
        logic [33:0] t;
        longint      d [3];
        acc  = '0;
        root = '0;
        d[0] = longint'(signed'(sph_x[i])) - longint'(signed'(sph_x[j]));
        d[1] = longint'(signed'(sph_y[i])) - longint'(signed'(sph_y[j]));
        d[2] = longint'(signed'(sph_z[i])) - longint'(signed'(sph_z[j]));
        for (int k = 0; k < 3; k++) begin
            u = (d[k] < 0) ? 68'(-d[k]) : 68'(d[k]);
            acc = acc + u * u;
        end
        for (int b = 33; b >= 0; b--) begin
            t  = root | (34'd1 << b);
            tt = 68'(t);
            if (tt * tt <= acc) root = t;
        end
        return longint'(root) - (longint'(sph_r[i]) + longint'(sph_r[j]));
    endfunction

    task automatic load_sphere(input t_sphere s);
        t_gap_result res;
        longint      cx, cy, cz, r, best, g;
        int          ix, iy, iz, b, f;
        bit          found;
        found = 0;
        best  = 0;
        if (sph_count < N_SPH) begin
            sph_x[sph_count] = s.cx;
            sph_y[sph_count] = s.cy;
            sph_z[sph_count] = s.cz;
            sph_r[sph_count] = {1'b0, s.rad};
            cx = s.cx;
            cy = s.cy;
            cz = s.cz;
            r  = s.rad;
            for (int c = 0; c < 8; c++) begin
                ix = axis_bin(cx + (c[2] ? r : -r), 0);
                iy = axis_bin(cy + (c[1] ? r : -r), 1);
                iz = axis_bin(cz + (c[0] ? r : -r), 2);
                b  = (ix * N_AX + iy) * N_AX + iz;
                f  = bin_fill[b];
                if (f > 0 && bin_member[b*N_PER + f - 1] == sph_count) continue;
                if (f < N_PER) begin
                    bin_member[b*N_PER + f] = sph_count;
                    bin_fill[b] = f + 1;
                end else begin
                    dropped = 1;
                end
            end
            sph_count++;
        end else begin
            dropped = 1;
        end
        if (!s.last) return;
        for (int cb = 0; cb < N_CELL; cb++)
            for (int i = 0; i < bin_fill[cb]; i++)
                for (int j = i + 1; j < bin_fill[cb]; j++) begin
                    g = surface_gap(bin_member[cb*N_PER + i], bin_member[cb*N_PER + j]);
                    if (!found || g < best) best = g;
                    found = 1;
                end
        if (!found) best = 64'h7FFF_FFFF;
        if (best > 64'sh7FFF_FFFF) best = 64'sh7FFF_FFFF;
        if (best < -64'sh8000_0000) best = -64'sh8000_0000;
        res.gap     = best[31:0];
        res.no_pair = !found;
        res.ovf     = dropped;
        gap_q = {gap_q, res};
        sph_count = 0;
        dropped   = 0;
        for (int cb = 0; cb < N_CELL; cb++) bin_fill[cb] = 0;
    endtask

    // driver
    bit took;
    int in_gap;
    int out_stall;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            took = 1;
            n_items++;
            load_sphere('{i_center_x, i_center_y, i_center_z, i_sphere_radius, i_last_sphere});
        end
    end

    always @(negedge i_clk) begin
        t_sphere s;
        logic    nv;
        if (i_rst_n && !(i_in_valid && !took)) begin
            took = 0;
            nv   = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_q.size() > 0) begin
                s = pending_q.pop_front();
                i_center_x      <= s.cx;
                i_center_y      <= s.cy;
                i_center_z      <= s.cz;
                i_sphere_radius <= s.rad;
                i_last_sphere   <= s.last;
                nv     = 1'b1;
                in_gap = burst ? 0 : $urandom_range(0, 17);
            end
            i_in_valid <= nv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_gap_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            out_stall = burst ? 0 : $urandom_range(0, 17);
            if (gap_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result gap=%h no_pair=%b ovf=%b",
                         $realtime, o_min_gap, o_no_pair, o_cell_overflow);
            end else begin
                e = gap_q.pop_front();
                if (e.ovf) n_overflow++;
                if (e.no_pair) n_nopair++;
                if (o_min_gap !== e.gap) begin
                    errors++;
                    $display("%0t: min_gap expected %h actual %h", $realtime, e.gap, o_min_gap);
                end
                if (o_no_pair !== e.no_pair) begin
                    errors++;
                    $display("%0t: no_pair expected %b actual %b",
                             $realtime, e.no_pair, o_no_pair);
                end
                if (o_cell_overflow !== e.ovf) begin
                    errors++;
                    $display("%0t: cell_overflow expected %b actual %b",
                             $realtime, e.ovf, o_cell_overflow);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx < REG_LEN_X) grid_cells[idx] = val[3:0];
        else grid_len[idx - REG_LEN_X] = val[LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int nx, ny, nz, input logic [30:0] lx, ly, lz);
        write_reg(REG_CELLS_X, CFG_W'(nx));
        write_reg(REG_CELLS_Y, CFG_W'(ny));
        write_reg(REG_CELLS_Z, CFG_W'(nz));
        write_reg(REG_LEN_X, lx);
        write_reg(REG_LEN_Y, ly);
        write_reg(REG_LEN_Z, lz);
        n_settings++;
    endtask

    task automatic queue_sphere(input logic [31:0] x, y, z, input logic [30:0] r,
                                input logic last);
        t_sphere s;
        s = '{x, y, z, r, last};
        pending_q = {pending_q, s};
        if (last) n_sets++;
    endtask

    task automatic drain();
        wait (n_results == n_sets);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] grid_coord(int k);
        int unsigned n;
        longint      span;
        n = (grid_cells[k] == 0) ? 1 : (grid_cells[k] > N_AX ? N_AX : grid_cells[k]);
        span = longint'(n) * longint'(grid_len[k] == 0 ? 1 : grid_len[k]);
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return -$urandom_range(0, 1000);
            default: return $urandom_range(0, int'(span));
        endcase
    endfunction

    initial begin
        int          set_n;
        logic [30:0] lens [3];
        logic [30:0] r;
        logic [31:0] lx;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_sets = 0;
        n_overflow = 0;
        n_nopair = 0;
        n_settings = 0;
        burst = 0;
        took = 0;
        in_gap = 0;
        out_stall = 0;
        sph_count = 0;
        dropped = 0;
        for (int k = 0; k < 3; k++) begin
            grid_cells[k] = 4'd1;
            grid_len[k]   = 31'd65536;
        end
        for (int cb = 0; cb < N_CELL; cb++) bin_fill[cb] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single grid cell at reset values
        queue_sphere(32'h0001_0000, 32'h0, 32'h0, 31'h1000, 1'b1);
        queue_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        queue_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
        queue_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h0, 1'b0);
        queue_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h0, 1'b1);
        queue_sphere(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31'h100, 1'b0);
        queue_sphere(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 31'h200, 1'b0);
        queue_sphere(32'hFFFF_0000, 32'h0000_4000, 32'h0000_1000, 31'h8000, 1'b1);
        drain();

        // zero counts and lengths, oversize counts
        set_grid(0, 15, 8, 31'd0, 31'h7FFF_FFFF, 31'd1);
        queue_sphere(32'h0000_0003, 32'h4000_0000, 32'h0000_0005, 31'h2, 1'b0);
        queue_sphere(32'h0000_0009, 32'h7000_0000, 32'h0000_0006, 31'h1, 1'b0);
        queue_sphere(32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0002, 31'h3, 1'b1);
        drain();

        // crowded cell drops members
        set_grid(8, 8, 8, 31'd65536, 31'd65536, 31'd65536);
        for (int i = 0; i < 34; i++)
            queue_sphere(32'h0000_8000 + i, 32'h0000_8000, 32'h0000_8000, 31'd16, i == 33);
        drain();

        // sphere store full: two per cell, one beyond the limit
        burst = 1;
        for (int i = 0; i <= N_SPH; i++)
            queue_sphere(((i / 64) % 8) * 65536 + 32768, ((i / 8) % 8) * 65536 + 32768,
                         (i % 8) * 65536 + 32768, 31'd0, i == N_SPH);
        drain();
        burst = 0;

        for (int ph = 0; ph < 8; ph++) begin
            for (int k = 0; k < 3; k++)
                case ($urandom_range(0, 5))
                    0: lens[k] = 31'h7FFF_FFFF;
                    1: lens[k] = 31'($urandom_range(0, 3));
                    2: lens[k] = 31'($urandom);
                    default: lens[k] = 31'($urandom_range(32'h1000, 32'h10_0000));
                endcase
            if (ph == 0) set_grid(8, 8, 8, lens[0], lens[1], lens[2]);
            else if (ph == 1) set_grid(1, 1, 1, lens[0], lens[1], lens[2]);
            else set_grid($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                          lens[0], lens[1], lens[2]);
            burst = (ph == 3);
            set_n = 0;
            while (set_n < 50) begin
                int sz;
                sz = $urandom_range(1, 12);
                for (int i = 0; i < sz; i++) begin
                    lx = (grid_len[0] == '0) ? 32'd1 : 32'(grid_len[0]);
                    case ($urandom_range(0, 7))
                        0: r = 31'($urandom);
                        1: r = 31'd0;
                        default: r = 31'($urandom_range(0, lx));
                    endcase
                    queue_sphere(grid_coord(0), grid_coord(1), grid_coord(2), r, i == sz - 1);
                end
                set_n += sz;
            end
            drain();
        end

        repeat (100) @(negedge i_clk);
        $display("Ran %0d spheres into %0d results over %0d grid settings", n_items, n_results,
                 n_settings + 1);
        $display("%0d results flagged overflow, %0d with no pair", n_overflow, n_nopair);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
